// ----- design/doubling_row_sparse_array_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DOUBLING_ROW_SPARSE_ARRAY_UNIT_DEFINES_SVH
`define DOUBLING_ROW_SPARSE_ARRAY_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DRSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define DRSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/drsa_pkg.sv -----
package drsa_pkg;

    localparam int IDX_W          = 10;
    localparam int IN_DATA_W      = 32;
    localparam int ROW_W          = 4;
    localparam int POS_W          = 9;
    localparam int HI_W           = 11;
    localparam int STAT_W         = 2;
    localparam int OP_W           = 2;
    localparam int CNT_W          = 10;
    localparam int FW             = 32;
    localparam int FBIT_W         = 5;
    localparam int FADDR_W        = IDX_W - FBIT_W;
    localparam int NFWORDS        = 2 ** FADDR_W;
    localparam int DEF_ROWS       = 10;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int S_TDATA_W      = 48;
    localparam int S_TUSER_W      = OP_W;
    localparam int M_TDATA_W      = 64;
    localparam int M_TUSER_W      = STAT_W;

    // Output word layout
    localparam int OUT_ROW_LSB    = IN_DATA_W;
    localparam int OUT_POS_LSB    = OUT_ROW_LSB + ROW_W;
    localparam int OUT_HI_LSB     = OUT_POS_LSB + POS_W;
    localparam int OUT_REL_BIT    = OUT_HI_LSB + HI_W;
    localparam int OUT_PAD_W      = M_TDATA_W - OUT_REL_BIT - 1;

    typedef enum logic [OP_W-1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_UNSET = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic               re;
        logic [FADDR_W-1:0] raddr;
        logic               we;
        logic [FADDR_W-1:0] waddr;
        logic [FW-1:0]      wdata;
    } t_flag_req;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
    } t_elem_req;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [POS_W-1:0] pos;
    } t_rowpos;

    // Row is the position of the leading one of index+1; position is what
    // remains once that bit is dropped.
    function automatic t_rowpos row_decode(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] n;
        int             r;
        t_rowpos        rp;
        n = {1'b0, idx} + (IDX_W+1)'(1);
        r = 0;
        for (int i = 0; i <= IDX_W; i++) begin
            if (n[i]) r = i;
        end
        rp.row = ROW_W'(r);
        rp.pos = POS_W'(n ^ ((IDX_W+1)'(1) << r));
        return rp;
    endfunction

    function automatic logic [FBIT_W-1:0] msb_pos(input logic [FW-1:0] w);
        logic [FBIT_W-1:0] p;
        p = '0;
        for (int i = 0; i < FW; i++) begin
            if (w[i]) p = FBIT_W'(i);
        end
        return p;
    endfunction

endpackage

// ----- design/drsa_elem_store.sv -----
module drsa_elem_store
    import drsa_pkg::*;
#(
    parameter int ROWS       = DEF_ROWS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  t_elem_req             i_req,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    localparam int DEPTH = (ROWS > IDX_W) ? 2 ** IDX_W : 2 ** ROWS - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/drsa_flag_store.sv -----
module drsa_flag_store
    import drsa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_flag_req     i_req,
    output logic [FW-1:0] o_rdata
);

    logic [FW-1:0]      r_mem [NFWORDS];
    logic [NFWORDS-1:0] r_valid;
    logic [FW-1:0]      r_rdata;
    logic               r_rvalid;

    // A word never written since reset reads as all clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_valid[i_req.raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ----- design/drsa_ctrl.sv -----
module drsa_ctrl
    import drsa_pkg::*;
#(
    parameter int ROWS       = DEF_ROWS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [OP_W-1:0]       i_op,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [IN_DATA_W-1:0]  i_value,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [STAT_W-1:0]     o_status,
    output logic [IN_DATA_W-1:0]  o_read_value,
    output logic [ROW_W-1:0]      o_row_number,
    output logic [POS_W-1:0]      o_row_position,
    output logic [HI_W-1:0]       o_highest_index,
    output logic                  o_row_released,
    output t_elem_req             o_elem_req,
    output logic [DATA_WIDTH-1:0] o_elem_wdata,
    input  logic [DATA_WIDTH-1:0] i_elem_rdata,
    output t_flag_req             o_flag_req,
    input  logic [FW-1:0]         i_flag_rdata
);

    localparam logic [IDX_W:0] CAP_LIM = (ROWS > IDX_W) ? (IDX_W+1)'(2 ** IDX_W)
                                                        : (IDX_W+1)'(2 ** ROWS - 1);
    localparam int NROW = (ROWS < IDX_W + 1) ? ROWS : IDX_W + 1;
    localparam int RIW  = (NROW > 1) ? $clog2(NROW) : 1;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [DATA_WIDTH-1:0]   r_val, n_val;
    logic signed [HI_W-1:0]  r_highest, n_highest;
    logic [FADDR_W-1:0]      r_scan, n_scan;
    logic [CNT_W-1:0]        r_cnt [2 ** RIW];

    logic                    r_m_valid, n_m_valid;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [IN_DATA_W-1:0]    r_rd, n_rd;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [HI_W-1:0]         r_hi, n_hi;
    logic                    r_rel, n_rel;

    t_rowpos                 rp;
    logic [RIW-1:0]          ri;
    logic                    in_range;
    logic [FW-1:0]           bit_mask;
    logic [FW-1:0]           below;
    logic                    was_set;
    logic [CNT_W-1:0]        cnt_old;
    logic                    cnt_wr;
    logic [CNT_W-1:0]        cnt_nx;
    logic                    out_free;
    logic [FADDR_W-1:0]      waddr;

    assign rp       = row_decode(r_idx);
    assign ri       = rp.row[RIW-1:0];
    assign in_range = {1'b0, r_idx} < CAP_LIM;
    assign bit_mask = FW'(1) << r_idx[FBIT_W-1:0];
    assign below    = i_flag_rdata & (bit_mask - FW'(1));
    assign was_set  = |(i_flag_rdata & bit_mask);
    assign cnt_old  = r_cnt[ri];
    assign waddr    = r_idx[IDX_W-1:FBIT_W];
    assign out_free = !r_m_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_highest <= '1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_highest <= n_highest;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2 ** RIW; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (cnt_wr) begin
            r_cnt[ri] <= cnt_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_scan   <= n_scan;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_row    <= n_row;
        r_pos    <= n_pos;
        r_hi     <= n_hi;
        r_rel    <= n_rel;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_idx      = r_idx;
        n_val      = r_val;
        n_highest  = r_highest;
        n_scan     = r_scan;
        n_m_valid  = r_m_valid;
        n_status   = r_status;
        n_rd       = r_rd;
        n_row      = r_row;
        n_pos      = r_pos;
        n_hi       = r_hi;
        n_rel      = r_rel;
        cnt_wr     = 1'b0;
        cnt_nx     = cnt_old;
        o_elem_req = '0;
        o_flag_req = '0;
        o_s_ready  = (r_state == S_IDLE);

        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_op             = t_op'(i_op);
                    n_idx            = i_index;
                    n_val            = DATA_WIDTH'($signed(i_value));
                    o_elem_req.re    = 1'b1;
                    o_elem_req.raddr = i_index;
                    o_flag_req.re    = 1'b1;
                    o_flag_req.raddr = i_index[IDX_W-1:FBIT_W];
                    n_state          = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_status  = ST_OK;
                    n_rd      = '0;
                    n_row     = rp.row;
                    n_pos     = rp.pos;
                    n_rel     = 1'b0;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (!in_range) begin
                        n_status = ST_RANGE;
                        n_row    = '0;
                        n_pos    = '0;
                    end else begin
                        case (r_op)
                            OP_SET: begin
                                o_elem_req.we    = 1'b1;
                                o_elem_req.waddr = r_idx;
                                o_flag_req.we    = 1'b1;
                                o_flag_req.waddr = waddr;
                                o_flag_req.wdata = i_flag_rdata | bit_mask;
                                if (!was_set) begin
                                    cnt_wr = 1'b1;
                                    cnt_nx = cnt_old + CNT_W'(1);
                                end
                                if ($signed({1'b0, r_idx}) > r_highest) begin
                                    n_highest = HI_W'(r_idx);
                                end
                            end
                            OP_GET: begin
                                if (was_set) begin
                                    n_rd = IN_DATA_W'(i_elem_rdata);
                                end else begin
                                    n_status = ST_UNSET;
                                end
                            end
                            OP_DEL: begin
                                if (!was_set) begin
                                    n_status = ST_UNSET;
                                end else begin
                                    o_flag_req.we    = 1'b1;
                                    o_flag_req.waddr = waddr;
                                    o_flag_req.wdata = i_flag_rdata & ~bit_mask;
                                    cnt_wr           = 1'b1;
                                    cnt_nx           = cnt_old - CNT_W'(1);
                                    n_rel            = (cnt_old == CNT_W'(1));
                                    if ($signed({1'b0, r_idx}) == r_highest) begin
                                        if (|below) begin
                                            n_highest = $signed({1'b0, waddr, msb_pos(below)});
                                        end else if (waddr == '0) begin
                                            n_highest = '1;
                                        end else begin
                                            // walk down one flag word per cycle
                                            o_flag_req.re    = 1'b1;
                                            o_flag_req.raddr = waddr - FADDR_W'(1);
                                            n_scan           = waddr - FADDR_W'(1);
                                            n_m_valid        = 1'b0;
                                            n_state          = S_SCAN;
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    n_hi = n_highest;
                end
            end
            S_SCAN: begin
                if (|i_flag_rdata) begin
                    n_highest = $signed({1'b0, r_scan, msb_pos(i_flag_rdata)});
                    n_hi      = n_highest;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_scan == '0) begin
                    n_highest = '1;
                    n_hi      = n_highest;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_flag_req.re    = 1'b1;
                    o_flag_req.raddr = r_scan - FADDR_W'(1);
                    n_scan           = r_scan - FADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_elem_wdata    = r_val;
    assign o_m_valid       = r_m_valid;
    assign o_status        = r_status;
    assign o_read_value    = r_rd;
    assign o_row_number    = r_row;
    assign o_row_position  = r_pos;
    assign o_highest_index = r_hi;
    assign o_row_released  = r_rel;

endmodule

// ----- design/doubling_row_sparse_array_unit.sv -----
// Sparse integer array over a doubling-row index space: row r holds 2^r
// entries, so an index falls in row floor(log2(index+1)). Each input word
// carries one operation (set, get, delete or no-op) on one entry and gives exactly
// one output word with a status, the read value of a get, the row and the
// offset of the entry, the highest set index after the operation and, for a
// delete, whether the row went empty. Indices at or above 2^ROWS-1 are
// rejected with status "out of range" and change nothing. Each item is
// accepted, then, once the output register is free, makes one read-modify-write
// pass through the element memory and the set-flag memory; only one item is in
// flight at a time, while the output register lets a finished word wait for the
// downstream side as the next word is taken. A delete of the current highest
// entry whose flag word holds no lower set entry scans the set-flag memory
// downward, one 32-entry flag word per cycle through its single read port.
// Set flags are cleared at reset through per-word valid bits, so no clearing
// pass is needed before the block takes its first input.
module doubling_row_sparse_array_unit
    import drsa_pkg::*;
#(
    parameter int ROWS       = DEF_ROWS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // index[9:0], value[41:10], zero pad
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // operation[1:0]
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_value[31:0], row_number[35:32],
                                                // row_position[44:36],
                                                // highest_index[55:45],
                                                // row_released[56], zero pad
    output logic [M_TUSER_W-1:0] m_axis_tuser   // status[1:0]
);

    t_elem_req             elem_req;
    logic [DATA_WIDTH-1:0] elem_wdata;
    logic [DATA_WIDTH-1:0] elem_rdata;
    t_flag_req             flag_req;
    logic [FW-1:0]         flag_rdata;

    logic [IN_DATA_W-1:0]  read_value;
    logic [ROW_W-1:0]      row_number;
    logic [POS_W-1:0]      row_position;
    logic [HI_W-1:0]       highest_index;
    logic                  row_released;

    // Sequencer: decodes the index, runs the read-modify-write and the
    // downward flag scan, and holds the result word.
    drsa_ctrl #(
        .ROWS       (ROWS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_valid       (s_axis_tvalid),
        .o_s_ready       (s_axis_tready),
        .i_op            (s_axis_tuser),
        .i_index         (s_axis_tdata[IDX_W-1:0]),
        .i_value         (s_axis_tdata[IDX_W +: IN_DATA_W]),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_status        (m_axis_tuser),
        .o_read_value    (read_value),
        .o_row_number    (row_number),
        .o_row_position  (row_position),
        .o_highest_index (highest_index),
        .o_row_released  (row_released),
        .o_elem_req      (elem_req),
        .o_elem_wdata    (elem_wdata),
        .i_elem_rdata    (elem_rdata),
        .o_flag_req      (flag_req),
        .i_flag_rdata    (flag_rdata)
    );

    // Value memory: written by set, read on every accept and used by get; no reset.
    drsa_elem_store #(
        .ROWS       (ROWS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_elem_store (
        .i_clk   (i_clk),
        .i_req   (elem_req),
        .i_wdata (elem_wdata),
        .o_rdata (elem_rdata)
    );

    // Set-flag memory: 32 flags per word, cleared at reset by word valid bits.
    drsa_flag_store u_flag_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (flag_req),
        .o_rdata (flag_rdata)
    );

    // Pack the result word, highest field first.
    assign m_axis_tdata = {OUT_PAD_W'(0), row_released, highest_index, row_position,
                           row_number, read_value};

endmodule

// ----- design/drsa_checker.sv -----
`include "doubling_row_sparse_array_unit_defines.svh"

module drsa_checker
    import drsa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // A stalled output word holds.
    `DRSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

    // One item at a time: the cycle after an accept takes no new word.
    `DRSA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in flight")

    // A rejected index reports no value and no row fields.
    `DRSA_ASSERT_IMP(a_range_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_RANGE), m_axis_tdata[OUT_HI_LSB-1:0] == '0, "out-of-range word carries data")

    // Only a successful delete releases a row, and it reads nothing.
    `DRSA_ASSERT_IMP(a_release_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[OUT_REL_BIT], (m_axis_tuser == ST_OK) && (m_axis_tdata[IN_DATA_W-1:0] == '0), "row release on a failed or reading operation")

endmodule

bind doubling_row_sparse_array_unit drsa_checker u_drsa_checker (.*);

// ----- test/tb_doubling_row_sparse_array_unit.sv -----
module tb_doubling_row_sparse_array_unit;
    import drsa_pkg::*;

    localparam int CAPACITY        = (1 << DEF_ROWS) - 1;
    localparam int RANDOM_WORDS    = 1000;
    localparam int PHASE_WORDS     = 250;
    localparam int CLUSTER_WORDS   = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 50;
    // Longest correct gap: the hold-off plus a full flag scan plus stalls.
    localparam int WATCHDOG_LIMIT  = 2000;

    // One output word, split into its fields.
    typedef struct packed {
        t_status     st;
        logic [31:0] rd;
        logic [3:0]  row;
        logic [8:0]  pos;
        logic [10:0] hi;
        logic        rel;
    } array_reply_t;

    // One directed stimulus row; typed rows carry their answer with them.
    typedef struct packed {
        t_op          op;
        logic [9:0]   idx;
        logic [31:0]  val;
        logic         typed;
        array_reply_t reply;
    } stim_row_t;

    // DUT ports
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata   = '0;  // index[9:0], value[41:10], zero pad
    logic [S_TUSER_W-1:0] s_axis_tuser   = '0;  // operation[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // read_value[31:0], row_number[35:32],
                                                // row_position[44:36],
                                                // highest_index[55:45],
                                                // row_released[56], zero pad
    logic [M_TUSER_W-1:0] m_axis_tuser;         // status[1:0]

    // Side band that travels with the word on the input bus
    logic         drv_typed = 1'b0;
    array_reply_t drv_reply = '0;

    // Shadow copy of the array
    logic [31:0]  arr_value [CAPACITY];
    bit           arr_set   [CAPACITY];
    int           row_fill  [DEF_ROWS];
    int           arr_top = -1;

    array_reply_t expected_replies [$];
    stim_row_t    dir_rows [$];

    int  errors         = 0;
    int  quiet_cycles   = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 1'b0;

    doubling_row_sparse_array_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the shadow array and return the word it must produce.
    function automatic array_reply_t apply_array_op(input t_op op, input logic [9:0] idx,
                                                    input logic [31:0] val);
        array_reply_t r;
        int           n;
        int           rw;
        int           k;
        r    = '0;
        r.st = ST_OK;
        if (int'(idx) >= CAPACITY) begin
            r.st = ST_RANGE;
        end else begin
            // Row is the bit length of index+1, minus one.
            n  = int'(idx) + 1;
            rw = 0;
            while ((n >> (rw + 1)) != 0) rw++;
            r.row = 4'(rw);
            r.pos = 9'(n - (1 << rw));
            case (op)
                OP_SET: begin
                    arr_value[idx] = val;
                    if (!arr_set[idx]) begin
                        arr_set[idx] = 1'b1;
                        row_fill[rw]++;
                    end
                    if (int'(idx) > arr_top) arr_top = int'(idx);
                end
                OP_GET: begin
                    if (arr_set[idx]) r.rd = arr_value[idx];
                    else r.st = ST_UNSET;
                end
                OP_DEL: begin
                    if (!arr_set[idx]) begin
                        r.st = ST_UNSET;
                    end else begin
                        arr_set[idx] = 1'b0;
                        row_fill[rw]--;
                        r.rel = (row_fill[rw] == 0);
                        // Losing the top entry: walk down to the next set one.
                        if (int'(idx) == arr_top) begin
                            k = int'(idx);
                            while (k >= 0 && !arr_set[k]) k--;
                            arr_top = k;
                        end
                    end
                end
                OP_NOP: ;
                default: ;
            endcase
        end
        r.hi = 11'(arr_top);
        return r;
    endfunction

    // Typed rows all run while the array is empty: no read data, top at minus one.
    function automatic stim_row_t typed_row(input t_op op, input logic [9:0] idx,
                                            input logic [31:0] val, input t_status st,
                                            input logic [3:0] row, input logic [8:0] pos);
        stim_row_t s;
        s           = '0;
        s.op        = op;
        s.idx       = idx;
        s.val       = val;
        s.typed     = 1'b1;
        s.reply.st  = st;
        s.reply.row = row;
        s.reply.pos = pos;
        s.reply.hi  = 11'h7FF;
        return s;
    endfunction

    function automatic stim_row_t pred_row(input t_op op, input logic [9:0] idx,
                                           input logic [31:0] val);
        stim_row_t s;
        s     = '0;
        s.op  = op;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Offer one word, idling first as the current phase asks; return once taken.
    task automatic offer_word(input t_op op, input logic [9:0] idx, input logic [31:0] val,
                              input logic typed, input array_reply_t reply);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, idx};
        s_axis_tuser  <= op;
        drv_typed     <= typed;
        drv_reply     <= reply;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Monitor both buses on each edge; values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        array_reply_t r;
        array_reply_t want;
        if (i_rst_n) begin
            // Predict the word just taken; a typed row overrides the prediction.
            if (s_axis_tvalid && s_axis_tready) begin
                r = apply_array_op(t_op'(s_axis_tuser), s_axis_tdata[9:0],
                                   s_axis_tdata[41:10]);
                if (drv_typed) r = drv_reply;
                expected_replies.push_back(r);
            end
            // Compare the word handed out against the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output word, expected none, got %0h/%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.st), 32'(m_axis_tuser));
                    check_field("read_value", want.rd, m_axis_tdata[31:0]);
                    check_field("row_number", 32'(want.row), 32'(m_axis_tdata[35:32]));
                    check_field("row_position", 32'(want.pos), 32'(m_axis_tdata[44:36]));
                    check_field("highest_index", 32'(want.hi), 32'(m_axis_tdata[55:45]));
                    check_field("row_released", 32'(want.rel), 32'(m_axis_tdata[56]));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Downstream side: stall at the phase rate, or hold off for a long stretch on request.
    initial begin
        repeat (7) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no word moves on either bus for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: watchdog expired, %0d words still due", $time,
                 expected_replies.size());
        $display("tb_doubling_row_sparse_array_unit NOT OK");
        $finish;
    end

    initial begin
        int           pick;
        int           lo_base;
        int           hi_base;
        t_op          op;
        logic [9:0]   idx;
        array_reply_t none;
        none    = '0;
        lo_base = 0;
        hi_base = 1015;

        // Directed words: extremes, every operation, range and unset errors,
        // overwrite, row release and scans for a new top entry.
        dir_rows = '{
            typed_row(OP_GET, 10'd0,    32'd0,         ST_UNSET, 4'd0, 9'd0),
            typed_row(OP_DEL, 10'd1022, 32'd0,         ST_UNSET, 4'd9, 9'd511),
            typed_row(OP_SET, 10'd1023, 32'hFFFF_FFFF, ST_RANGE, 4'd0, 9'd0),
            typed_row(OP_NOP, 10'd1023, 32'd0,         ST_RANGE, 4'd0, 9'd0),
            typed_row(OP_GET, 10'd1023, 32'd0,         ST_RANGE, 4'd0, 9'd0),
            typed_row(OP_DEL, 10'd1023, 32'd0,         ST_RANGE, 4'd0, 9'd0),
            pred_row(OP_NOP, 10'd5,    32'h1234_5678),
            pred_row(OP_SET, 10'd0,    32'h7FFF_FFFF),
            pred_row(OP_SET, 10'd1022, 32'h8000_0000),
            pred_row(OP_GET, 10'd1022, 32'd0),
            pred_row(OP_GET, 10'd0,    32'd0),
            pred_row(OP_SET, 10'd1,    32'hFFFF_FFFF),
            pred_row(OP_SET, 10'd2,    32'd0),
            pred_row(OP_SET, 10'd1,    32'd123),
            pred_row(OP_GET, 10'd1,    32'd0),
            pred_row(OP_DEL, 10'd1,    32'd0),
            pred_row(OP_DEL, 10'd2,    32'd0),
            pred_row(OP_DEL, 10'd1022, 32'd0),
            pred_row(OP_GET, 10'd1022, 32'd0),
            pred_row(OP_SET, 10'd511,  32'h5555_5555),
            pred_row(OP_SET, 10'd512,  32'hAAAA_AAAA),
            pred_row(OP_DEL, 10'd512,  32'd0),
            pred_row(OP_DEL, 10'd511,  32'd0),
            pred_row(OP_DEL, 10'd0,    32'd0),
            typed_row(OP_DEL, 10'd0,   32'd0,          ST_UNSET, 4'd0, 9'd0)
        };

        // Hold reset, then release it once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                       dir_rows[i].typed, dir_rows[i].reply);

        // Random words: mostly two small clusters, one low and one high, so that
        // gets and deletes hit set entries and deleting the top scans far down.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_WORDS == 0) begin
                case (n / PHASE_WORDS)
                    0: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                        hold_request   = 1'b1;  // fill the block while the sink waits
                    end
                    1: begin
                        send_idle_pct  = 49;
                        recv_stall_pct = 0;
                    end
                    2: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 49;
                    end
                    default: begin
                        send_idle_pct  = 22;
                        recv_stall_pct = 22;
                    end
                endcase
            end
            if (n % CLUSTER_WORDS == 0) begin
                lo_base = $urandom_range(200);
                hi_base = $urandom_range(1015, 300);
            end
            pick = $urandom_range(99);
            if (pick < 5)       idx = 10'h3FF;
            else if (pick < 25) idx = 10'($urandom_range(1022));
            else if (pick < 60) idx = 10'(lo_base + $urandom_range(7));
            else                idx = 10'(hi_base + $urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 40)      op = OP_SET;
            else if (pick < 65) op = OP_GET;
            else if (pick < 95) op = OP_DEL;
            else                op = OP_NOP;
            offer_word(op, idx, $urandom, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every due word, then let a few more cycles pass.
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_replies.size() == 0)
            $display("tb_doubling_row_sparse_array_unit OK");
        else
            $display("tb_doubling_row_sparse_array_unit NOT OK");
        $finish;
    end

endmodule
